FILE: rtl/core/assert_macros.svh
// assertion macros for the drum voice slot allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define DVSA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define DVSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);
`else
`define DVSA_ASSERT(label, prop, msg)
`define DVSA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/core/dvsa_pkg.sv
// shared constants, codes and handshake structs of the voice slot allocator
`default_nettype none
package dvsa_pkg;

    localparam int VOICE_SLOTS = 8;
    localparam int SOUND_COUNT = 16;
    localparam int POS_W       = 16;
    localparam int CMD_W       = 2;
    localparam int SID_W       = 4;
    localparam int KIND_W      = 2;
    localparam int STAT_W      = 2;
    localparam int SLOT_W      = $clog2(VOICE_SLOTS);
    localparam int CNT_W       = $clog2(VOICE_SLOTS + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_PLAY    = 2'd0,
        CMD_STOP    = 2'd1,
        CMD_STOPALL = 2'd2,
        CMD_TICK    = 2'd3
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK     = 2'd0,
        KIND_REPORT  = 2'd1,
        KIND_SILENCE = 2'd2
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE     = 2'd0,
        STAT_PLAYING  = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic cap;   // capture input word
        logic exec;  // run play / stop / stop-all and load ack
        logic step;  // walk one slot of a tick
        logic sil;   // load silence word
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic out_free;
        logic step_ok;
        logic idx_end;
        logic quiet;
    } stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/dvsa_ctrl.sv
// controller state machine of the voice slot allocator
`default_nettype none
module dvsa_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire dvsa_pkg::stat_t st,
    output dvsa_pkg::ctrl_t     ctrl
);
    import dvsa_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_WALK = 4'b0100,
        ST_SIL  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl.cap   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (st.is_tick) begin
                    state_next = ST_WALK;
                end else if (st.out_free) begin
                    ctrl.exec  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_WALK: begin
                ctrl.step = 1'b1;
                if (st.step_ok && st.idx_end) begin
                    state_next = st.quiet ? ST_SIL : ST_IDLE;
                end
            end
            ST_SIL: begin
                if (st.out_free) begin
                    ctrl.sil   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/dvsa_datapath.sv
// slot store, search logic, tick walk and output register
`default_nettype none
`include "assert_macros.svh"
module dvsa_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [dvsa_pkg::CMD_W-1:0]    s_cmd,
    input  wire logic [dvsa_pkg::SID_W-1:0]    s_sound_id,
    input  wire logic [dvsa_pkg::POS_W-1:0]    s_sound_length,
    input  wire dvsa_pkg::ctrl_t               ctrl,
    output dvsa_pkg::stat_t                    st,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [dvsa_pkg::KIND_W-1:0]        m_kind,
    output logic [dvsa_pkg::STAT_W-1:0]        m_status,
    output logic [dvsa_pkg::SLOT_W-1:0]        m_slot,
    output logic [dvsa_pkg::SID_W-1:0]         m_voice_sound,
    output logic [dvsa_pkg::POS_W-1:0]         m_position,
    output logic                               m_last
);
    import dvsa_pkg::*;

    // captured command
    cmd_t              cmd_reg, cmd_next;
    logic [SID_W-1:0]  sid_reg, sid_next;
    logic [POS_W-1:0]  len_reg, len_next;

    // tick walk
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              any_sent_reg, any_sent_next;

    // slot store
    logic [VOICE_SLOTS-1:0] busy_reg, busy_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [SID_W-1:0]       sound_reg [VOICE_SLOTS];
    logic [SID_W-1:0]       sound_next [VOICE_SLOTS];
    logic [POS_W-1:0]       pos_reg [VOICE_SLOTS];
    logic [POS_W-1:0]       pos_next [VOICE_SLOTS];
    logic [POS_W-1:0]       slen_reg [VOICE_SLOTS];
    logic [POS_W-1:0]       slen_next [VOICE_SLOTS];

    // output word
    logic              m_valid_reg, m_valid_next;
    kind_t             kind_reg, kind_next;
    status_t           status_reg, status_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SID_W-1:0]  vsound_reg, vsound_next;
    logic [POS_W-1:0]  position_reg, position_next;
    logic              last_reg, last_next;

    logic [VOICE_SLOTS-1:0] match_vec, free_vec, rep_vec, above_vec;
    logic              match_any, free_any;
    logic [SLOT_W-1:0] match_idx, free_idx;
    logic              out_free, cur_busy, cur_rep, step_ok;
    logic              pos_ok;

    assign out_free = !m_valid_reg || m_ready;

    // per-slot compares and lowest-index pick
    always_comb begin
        match_any = 1'b0;
        free_any  = 1'b0;
        match_idx = '0;
        free_idx  = '0;
        pos_ok    = 1'b1;
        for (int j = 0; j < VOICE_SLOTS; j++) begin
            match_vec[j] = busy_reg[j] && (sound_reg[j] == sid_reg);
            free_vec[j]  = !busy_reg[j];
            rep_vec[j]   = busy_reg[j] && (pos_reg[j] < slen_reg[j]);
            above_vec[j] = SLOT_W'(j) > idx_reg;
            if (busy_reg[j] && (pos_reg[j] > slen_reg[j])) begin
                pos_ok = 1'b0;
            end
        end
        for (int j = VOICE_SLOTS - 1; j >= 0; j--) begin
            if (match_vec[j]) begin
                match_any = 1'b1;
                match_idx = SLOT_W'(j);
            end
            if (free_vec[j]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(j);
            end
        end
    end

    assign cur_busy = busy_reg[idx_reg];
    assign cur_rep  = rep_vec[idx_reg];
    assign step_ok  = !cur_rep || out_free;

    assign st.is_tick  = (cmd_reg == CMD_TICK);
    assign st.out_free = out_free;
    assign st.step_ok  = step_ok;
    assign st.idx_end  = (idx_reg == SLOT_W'(VOICE_SLOTS - 1));
    assign st.quiet    = !any_sent_reg && !cur_rep;

    always_comb begin
        cmd_next      = cmd_reg;
        sid_next      = sid_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        any_sent_next = any_sent_reg;
        busy_next     = busy_reg;
        cnt_next      = cnt_reg;
        sound_next    = sound_reg;
        pos_next      = pos_reg;
        slen_next     = slen_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        kind_next     = kind_reg;
        status_next   = status_reg;
        slot_next     = slot_reg;
        vsound_next   = vsound_reg;
        position_next = position_reg;
        last_next     = last_reg;

        if (ctrl.cap) begin
            cmd_next      = cmd_t'(s_cmd);
            sid_next      = s_sound_id;
            len_next      = s_sound_length;
            idx_next      = '0;
            any_sent_next = 1'b0;
        end

        if (ctrl.exec) begin
            m_valid_next  = 1'b1;
            kind_next     = KIND_ACK;
            status_next   = STAT_DONE;
            slot_next     = '0;
            vsound_next   = sid_reg;
            position_next = '0;
            last_next     = 1'b1;
            case (cmd_reg)
                CMD_PLAY: begin
                    if (32'(sid_reg) >= SOUND_COUNT) begin
                        status_next = STAT_NOTFOUND;
                    end else if (cnt_reg >= CNT_W'(VOICE_SLOTS)) begin
                        status_next = STAT_FULL;
                    end else if (match_any) begin
                        status_next = STAT_PLAYING;
                        slot_next   = match_idx;
                    end else if (free_any) begin
                        slot_next            = free_idx;
                        busy_next[free_idx]  = 1'b1;
                        sound_next[free_idx] = sid_reg;
                        pos_next[free_idx]   = '0;
                        slen_next[free_idx]  = len_reg;
                        cnt_next             = cnt_reg + CNT_W'(1);
                    end else begin
                        status_next = STAT_FULL;
                    end
                end
                CMD_STOP: begin
                    if (match_any) begin
                        slot_next           = match_idx;
                        busy_next[match_idx] = 1'b0;
                        pos_next[match_idx]  = '0;
                        if (cnt_reg != '0) begin
                            cnt_next = cnt_reg - CNT_W'(1);
                        end
                    end else begin
                        status_next = STAT_NOTFOUND;
                    end
                end
                CMD_STOPALL: begin
                    vsound_next = '0;
                    busy_next   = '0;
                    cnt_next    = '0;
                    for (int j = 0; j < VOICE_SLOTS; j++) begin
                        pos_next[j] = '0;
                    end
                end
                default: begin
                    m_valid_next = m_valid_reg && !m_ready;
                end
            endcase
        end

        if (ctrl.step && step_ok) begin
            idx_next = idx_reg + SLOT_W'(1);
            if (cur_rep) begin
                m_valid_next      = 1'b1;
                kind_next         = KIND_REPORT;
                status_next       = STAT_DONE;
                slot_next         = idx_reg;
                vsound_next       = sound_reg[idx_reg];
                position_next     = pos_reg[idx_reg];
                last_next         = !(|(rep_vec & above_vec));
                pos_next[idx_reg] = pos_reg[idx_reg] + POS_W'(1);
                any_sent_next     = 1'b1;
            end else if (cur_busy) begin
                // length reached, freed without a report
                busy_next[idx_reg] = 1'b0;
                if (cnt_reg != '0) begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
        end

        if (ctrl.sil) begin
            m_valid_next  = 1'b1;
            kind_next     = KIND_SILENCE;
            status_next   = STAT_DONE;
            slot_next     = '0;
            vsound_next   = '0;
            position_next = '0;
            last_next     = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            any_sent_reg <= 1'b0;
            busy_reg     <= '0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
            cmd_reg      <= CMD_PLAY;
        end else begin
            idx_reg      <= idx_next;
            any_sent_reg <= any_sent_next;
            busy_reg     <= busy_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
            cmd_reg      <= cmd_next;
        end
    end

    always_ff @(posedge aclk) begin
        sid_reg      <= sid_next;
        len_reg      <= len_next;
        sound_reg    <= sound_next;
        pos_reg      <= pos_next;
        slen_reg     <= slen_next;
        kind_reg     <= kind_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        vsound_reg   <= vsound_next;
        position_reg <= position_next;
        last_reg     <= last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = kind_reg;
    assign m_status      = status_reg;
    assign m_slot        = slot_reg;
    assign m_voice_sound = vsound_reg;
    assign m_position    = position_reg;
    assign m_last        = last_reg;

    `DVSA_ASSERT(a_count_matches, cnt_reg == CNT_W'($countones(busy_reg)), "busy count out of step")
    `DVSA_ASSERT(a_pos_in_range, pos_ok, "busy slot position beyond its length")
    `DVSA_ASSERT(a_single_word_last, (m_valid_reg && kind_reg != KIND_REPORT) |-> last_reg, "ack or silence without last")
    `DVSA_ASSERT_NEXT(a_stopall_clears, ctrl.exec && cmd_reg == CMD_STOPALL, busy_reg == '0 && cnt_reg == '0, "stop-all left a slot busy")

endmodule
`default_nettype wire

FILE: rtl/core/drum_voice_slot_allocator_core.sv
// top level of the drum voice slot allocator: controller plus datapath
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    s_cmd, s_sound_id, s_sound_length
//   m_       out  m_valid/m_ready    m_kind, m_status, m_slot, m_voice_sound,
//                                    m_position, m_last
//
// play, stop and stop-all: word accepted in idle, then applied and the ack loaded once
//   the output register is free; no new word is taken before that ack is loaded
// tick: walks the slots one per cycle while no report waits on the output register,
//   then loads a silence word if no slot gave a report
// a report waits in the walk while the output register is still held by m_ready
// reset (aresetn low, synchronous) frees all slots and empties the output
`default_nettype none
module drum_voice_slot_allocator_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [dvsa_pkg::CMD_W-1:0]    s_cmd,
    input  wire logic [dvsa_pkg::SID_W-1:0]    s_sound_id,
    input  wire logic [dvsa_pkg::POS_W-1:0]    s_sound_length,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [dvsa_pkg::KIND_W-1:0]        m_kind,
    output logic [dvsa_pkg::STAT_W-1:0]        m_status,
    output logic [dvsa_pkg::SLOT_W-1:0]        m_slot,
    output logic [dvsa_pkg::SID_W-1:0]         m_voice_sound,
    output logic [dvsa_pkg::POS_W-1:0]         m_position,
    output logic                               m_last
);
    import dvsa_pkg::*;

    // command and status between the two halves
    ctrl_t ctrl;
    stat_t st;

    // sequencing: capture, dispatch, walk, silence
    dvsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .ctrl    (ctrl)
    );

    // slot store, search and the registered output word
    dvsa_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_cmd          (s_cmd),
        .s_sound_id     (s_sound_id),
        .s_sound_length (s_sound_length),
        .ctrl           (ctrl),
        .st             (st),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_status       (m_status),
        .m_slot         (m_slot),
        .m_voice_sound  (m_voice_sound),
        .m_position     (m_position),
        .m_last         (m_last)
    );

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// testbench for the drum voice slot allocator: random and directed words against a predictor
`default_nettype none
module tb_top;
    import dvsa_pkg::*;

    // one command word waiting to be driven
    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [SID_W-1:0] sid;
        logic [POS_W-1:0] len;
        bit               drain_first;  // hold off until every result word is back
    } cmd_word_t;

    // one result word as the block should present it
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [SID_W-1:0]  sound;
        logic [POS_W-1:0]  pos;
        logic              last;
    } result_word_t;

    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [CMD_W-1:0]  s_cmd          = '0;
    logic [SID_W-1:0]  s_sound_id     = '0;
    logic [POS_W-1:0]  s_sound_length = '0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic [KIND_W-1:0] m_kind;
    logic [STAT_W-1:0] m_status;
    logic [SLOT_W-1:0] m_slot;
    logic [SID_W-1:0]  m_voice_sound;
    logic [POS_W-1:0]  m_position;
    logic              m_last;

    cmd_word_t    pending_words[$];
    result_word_t expected_words[$];
    int unsigned  error_count = 0;

    // predictor copy of the slot store
    bit               voice_busy[VOICE_SLOTS];
    logic [SID_W-1:0] voice_sound[VOICE_SLOTS];
    logic [POS_W-1:0] voice_pos[VOICE_SLOTS];
    logic [POS_W-1:0] voice_len[VOICE_SLOTS];
    int unsigned      voices_active = 0;

    // the final word of a command is only known once the command is done,
    // so the newest word is held back until the next one or the end
    result_word_t staged_word;
    bit           staged_ok = 0;

    always #6 aclk = ~aclk;

    drum_voice_slot_allocator_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_sound_id    (s_sound_id),
        .s_sound_length(s_sound_length),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_status      (m_status),
        .m_slot        (m_slot),
        .m_voice_sound (m_voice_sound),
        .m_position    (m_position),
        .m_last        (m_last)
    );

    function automatic void stage_word(logic [KIND_W-1:0] kind, logic [STAT_W-1:0] status,
                                       int slot, logic [SID_W-1:0] sound,
                                       logic [POS_W-1:0] pos);
        if (staged_ok) begin
            expected_words.push_back(staged_word);
        end
        staged_word.kind   = kind;
        staged_word.status = status;
        staged_word.slot   = slot[SLOT_W-1:0];
        staged_word.sound  = sound;
        staged_word.pos    = pos;
        staged_word.last   = 1'b0;
        staged_ok          = 1;
    endfunction

    // works out the result words of one accepted command and updates the slots
    function automatic void predict_voices(logic [CMD_W-1:0] cmd, logic [SID_W-1:0] sid,
                                           logic [POS_W-1:0] len);
        bit found;
        int hit;
        int reports;
        found   = 0;
        hit     = 0;
        reports = 0;
        case (cmd)
            CMD_PLAY: begin
                if (sid >= SOUND_COUNT) begin
                    stage_word(KIND_ACK, STAT_NOTFOUND, 0, sid, '0);
                end else if (voices_active >= VOICE_SLOTS) begin
                    // full is checked before already playing
                    stage_word(KIND_ACK, STAT_FULL, 0, sid, '0);
                end else begin
                    for (int i = 0; i < VOICE_SLOTS; i++) begin
                        if (!found && voice_busy[i] && voice_sound[i] == sid) begin
                            found = 1;
                            hit   = i;
                        end
                    end
                    if (found) begin
                        stage_word(KIND_ACK, STAT_PLAYING, hit, sid, '0);
                    end else begin
                        for (int i = 0; i < VOICE_SLOTS; i++) begin
                            if (!found && !voice_busy[i]) begin
                                found = 1;
                                hit   = i;
                            end
                        end
                        voice_busy[hit]  = 1;
                        voice_sound[hit] = sid;
                        voice_pos[hit]   = '0;
                        voice_len[hit]   = len;
                        voices_active++;
                        stage_word(KIND_ACK, STAT_DONE, hit, sid, '0);
                    end
                end
            end
            CMD_STOP: begin
                for (int i = 0; i < VOICE_SLOTS; i++) begin
                    if (!found && voice_busy[i] && voice_sound[i] == sid) begin
                        found = 1;
                        hit   = i;
                    end
                end
                if (found) begin
                    voice_busy[hit] = 0;
                    voice_pos[hit]  = '0;
                    if (voices_active > 0) voices_active--;
                    stage_word(KIND_ACK, STAT_DONE, hit, sid, '0);
                end else begin
                    stage_word(KIND_ACK, STAT_NOTFOUND, 0, sid, '0);
                end
            end
            CMD_STOPALL: begin
                for (int i = 0; i < VOICE_SLOTS; i++) begin
                    voice_busy[i] = 0;
                    voice_pos[i]  = '0;
                end
                voices_active = 0;
                stage_word(KIND_ACK, STAT_DONE, 0, '0, '0);
            end
            default: begin
                if (voices_active != 0) begin
                    for (int i = 0; i < VOICE_SLOTS; i++) begin
                        if (voice_busy[i]) begin
                            if (voice_pos[i] < voice_len[i]) begin
                                stage_word(KIND_REPORT, STAT_DONE, i, voice_sound[i],
                                           voice_pos[i]);
                                voice_pos[i] = voice_pos[i] + 1'b1;
                                reports++;
                            end else begin
                                // end of sound: freed quietly, position kept
                                voice_busy[i] = 0;
                                if (voices_active > 0) voices_active--;
                            end
                        end
                    end
                end
                if (reports == 0) begin
                    stage_word(KIND_SILENCE, STAT_DONE, 0, '0, '0);
                end
            end
        endcase
        staged_word.last = 1'b1;
        expected_words.push_back(staged_word);
        staged_ok = 0;
    endfunction

    // idle length: mostly none or short, a few long, with calm stretches of none
    function automatic int unsigned next_gap(inout int unsigned calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void add_cmd(logic [CMD_W-1:0] cmd, logic [SID_W-1:0] sid,
                                    logic [POS_W-1:0] len, bit drain_first);
        cmd_word_t w;
        w.cmd         = cmd;
        w.sid         = sid;
        w.len         = len;
        w.drain_first = drain_first;
        pending_words.push_back(w);
    endfunction

    // driver: presents queued command words, keeps valid and payload steady until taken
    int unsigned send_gap  = 0;
    int unsigned send_calm = 0;

    always @(posedge aclk) begin
        cmd_word_t w;
        bit        holding;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap  = 0;
        end else begin
            holding = s_valid;
            if (s_valid && s_ready) begin
                predict_voices(s_cmd, s_sound_id, s_sound_length);
                holding  = 0;
                send_gap = next_gap(send_calm);
            end
            if (!holding) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_words.size() > 0 &&
                             (!pending_words[0].drain_first || expected_words.size() == 0)) begin
                    w = pending_words.pop_front();
                    s_valid        <= 1'b1;
                    s_cmd          <= w.cmd;
                    s_sound_id     <= w.sid;
                    s_sound_length <= w.len;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random backpressure, every taken word checked against the oldest expectation
    int unsigned recv_stall = 0;
    int unsigned recv_calm  = 0;
    int unsigned word_index = 0;

    always @(posedge aclk) begin
        result_word_t got;
        result_word_t want;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_kind, m_status, m_slot, m_voice_sound, m_position, m_last};
                if (expected_words.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $write("unexpected word %0d: kind %0d status %0d slot %0d",
                               word_index, got.kind, got.status, got.slot);
                        $display(" sound %0d pos %0d last %0d",
                                 got.sound, got.pos, got.last);
                    end
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $write("word %0d mismatch: exp kind %0d status %0d slot %0d",
                                   word_index, want.kind, want.status, want.slot);
                            $write(" sound %0d pos %0d last %0d,",
                                   want.sound, want.pos, want.last);
                            $write(" got kind %0d status %0d slot %0d",
                                   got.kind, got.status, got.slot);
                            $display(" sound %0d pos %0d last %0d",
                                     got.sound, got.pos, got.last);
                        end
                    end
                end
                word_index++;
                recv_stall = next_gap(recv_calm);
            end else if (recv_stall == 0 && $urandom_range(0, 19) == 0) begin
                recv_stall = next_gap(recv_calm);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // stimulus and end of run
    initial begin
        int unsigned r;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] len;

        // directed: empty store, zero length, max length, fill up, full, stops
        add_cmd(CMD_TICK, 4'd0, 16'd0, 0);        // silence with nothing busy
        add_cmd(CMD_STOP, 4'd5, 16'hFFFF, 0);     // stop with nothing playing
        add_cmd(CMD_STOPALL, 4'd0, 16'd0, 0);
        add_cmd(CMD_PLAY, 4'd0, 16'd0, 0);        // zero length takes a slot
        add_cmd(CMD_TICK, 4'd0, 16'd0, 0);        // freed quietly, silence
        add_cmd(CMD_PLAY, 4'd15, 16'hFFFF, 0);
        add_cmd(CMD_PLAY, 4'd15, 16'd3, 0);       // already playing
        for (int i = 1; i < 8; i++) begin
            add_cmd(CMD_PLAY, i[SID_W-1:0], i[POS_W-1:0], 0);
        end
        add_cmd(CMD_PLAY, 4'd9, 16'd4, 0);        // all slots busy
        add_cmd(CMD_PLAY, 4'd15, 16'd4, 0);       // full wins over already playing
        add_cmd(CMD_TICK, 4'd0, 16'd0, 0);
        add_cmd(CMD_TICK, 4'd0, 16'd0, 0);
        add_cmd(CMD_STOP, 4'd3, 16'd0, 0);
        add_cmd(CMD_STOP, 4'd3, 16'd0, 0);        // second stop finds nothing
        add_cmd(CMD_TICK, 4'd0, 16'd0, 0);
        add_cmd(CMD_STOPALL, 4'd0, 16'd0, 0);
        add_cmd(CMD_TICK, 4'd0, 16'd0, 1);        // silence again, after a full drain

        // random: plays with mostly short sounds and plenty of ticks keep slots turning over
        for (int i = 0; i < 357; i++) begin
            r = $urandom_range(0, 99);
            if (r < 38)      cmd = CMD_PLAY;
            else if (r < 78) cmd = CMD_TICK;
            else if (r < 95) cmd = CMD_STOP;
            else             cmd = CMD_STOPALL;
            if ($urandom_range(0, 9) == 0) len = POS_W'($urandom_range(0, 65535));
            else                           len = POS_W'($urandom_range(0, 12));
            add_cmd(cmd, SID_W'($urandom_range(0, 15)), len, (i == 150 || i == 300));
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || s_valid) @(posedge aclk);
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog
    initial begin
        #12000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
